// File: src/lfds_pkg.sv
// Shared types and constants of the link failover default selector.
package lfds_pkg;

	localparam int ID_W       = 8;
	localparam int ID_FIELDS  = 4;
	localparam int FUNC_W     = 3;
	localparam int COUNT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_KINDS  = 3;

	// Event codes.
	localparam logic [FUNC_W-1:0] FN_CTRL_DOWN  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_CTRL_UP    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SIG_LOW    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SIG_HIGH   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_BMP_DOWN   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_BMP_UP     = 3'd5;
	localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd6;
	localparam logic [FUNC_W-1:0] FN_RESERVED   = 3'd7;

	// Mark kinds, selected by the upper two bits of the event code.
	localparam logic [1:0] KIND_CTRL = 2'd0;
	localparam logic [1:0] KIND_SIG  = 2'd1;
	localparam logic [1:0] KIND_BMP  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_IDS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_HIGH_ID = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_LOW_ID  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFER_LARGE = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_COMMIT,
		ST_DONE
	} lfds_state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic scan;
		logic commit;
	} lfds_cmd_t;

	typedef struct packed {
		logic reselect;
		logic scan_last;
	} lfds_sts_t;

	typedef struct packed {
		logic            default_changed;
		logic            link_is_up;
		logic [ID_W-1:0] high_id;
		logic [ID_W-1:0] low_id;
		logic            id_unknown;
	} lfds_res_t;

endpackage

// File: src/lfds_chan_if.sv
// Event and result channel interfaces of the link failover default selector.
interface lfds_evt_if import lfds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   link_id;

	modport source (output valid, output func, output link_id, input ready);
	modport sink (input valid, input func, input link_id, output ready);
endinterface

interface lfds_res_if import lfds_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            default_changed;
	logic            link_is_up;
	logic [ID_W-1:0] high_id;
	logic [ID_W-1:0] low_id;
	logic            id_unknown;

	modport source (output valid, output default_changed, output link_is_up,
		output high_id, output low_id, output id_unknown, input ready);
	modport sink (input valid, input default_changed, input link_is_up,
		input high_id, input low_id, input id_unknown, output ready);
endinterface

// File: src/link_failover_default_selector.sv
// Link failover default selector: per-link failure marks and default link reselection.
// Each event beat is taken only while the block is idle. An event passes through the
// mark update and then the commit; when a link goes down, or comes up after its
// last mark clears, and the defaults are not fixed, a scan over min(MAX_LINKS, 4) link
// slots with one comparator row per cycle runs in between. The result beat is offered
// after the commit, and the next event can be taken in the cycle after the result beat
// is taken. Configuration writes are registered and belong to idle periods; writing
// an initial default id also loads the current default.
module link_failover_default_selector import lfds_pkg::*; #(
	parameter int MAX_LINKS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lfds_evt_if.sink              evt,
	lfds_res_if.source            res
);

	lfds_cmd_t cmd;
	lfds_sts_t sts;
	lfds_res_t result;

	lfds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (evt.valid),
		.in_ready  (evt.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfds_dp #(
		.MAX_LINKS (MAX_LINKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.evt_func    (evt.func),
		.evt_link_id (evt.link_id),
		.cmd         (cmd),
		.sts         (sts),
		.res         (result)
	);

	assign res.default_changed = result.default_changed;
	assign res.link_is_up      = result.link_is_up;
	assign res.high_id         = result.high_id;
	assign res.low_id          = result.low_id;
	assign res.id_unknown      = result.id_unknown;

endmodule

// File: src/lfds_ctrl.sv
// Sequencer of the link failover default selector: event load, update, scan, commit.
module lfds_ctrl import lfds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  lfds_sts_t sts,
	output lfds_cmd_t cmd
);

	lfds_state_t state_q;
	lfds_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = sts.reselect ? ST_SCAN : ST_COMMIT;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("event taken while a result beat is pending");

	a_load_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_UPDATE)
		else $error("accepted event did not enter the update step");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.update, cmd.scan, cmd.commit}))
		else $error("more than one datapath command at once");

endmodule

// File: src/lfds_dp.sv
// Datapath of the link failover default selector: config, marks, scan and result.
module lfds_dp import lfds_pkg::*; #(
	parameter int MAX_LINKS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [FUNC_W-1:0]     evt_func,
	input  logic [ID_W-1:0]       evt_link_id,
	input  lfds_cmd_t             cmd,
	output lfds_sts_t             sts,
	output lfds_res_t             res
);

	localparam int SLOTS = (MAX_LINKS < ID_FIELDS) ? MAX_LINKS : ID_FIELDS;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [COUNT_W-1:0]        link_count_q;
	logic [ID_W*ID_FIELDS-1:0] link_ids_q;
	logic                      fixed_q;
	logic                      prefer_q;
	logic [ID_W-1:0]           high_def_q;
	logic [ID_W-1:0]           low_def_q;
	logic [NUM_KINDS-1:0]      mark_q [SLOTS];

	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic              reselect_q;
	logic              changed_q;
	logic              up_q;
	logic              unknown_q;
	logic [SW-1:0]     scan_idx_q;
	logic              any_q;
	logic [ID_W-1:0]   lo_q;
	logic [ID_W-1:0]   hi_q;

	logic [ID_W-1:0]      slot_id [SLOTS];
	logic [SLOTS-1:0]     in_use;
	logic [SLOTS-1:0]     match;
	logic [NUM_KINDS-1:0] kind_mask;
	logic                 known;
	logic                 any_mark;
	logic                 has_kind;
	logic                 other_mark;
	logic                 evt_active;
	logic                 set_ev;
	logic                 clr_ev;
	logic                 need;
	logic [ID_W-1:0]      scan_id;
	logic                 scan_up;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			slot_id[s] = link_ids_q[s*ID_W +: ID_W];
			in_use[s]  = link_count_q > COUNT_W'(s);
			match[s]   = in_use[s] && (slot_id[s] == id_q);
		end
	end

	always_comb begin
		unique case (func_q[FUNC_W-1:1])
			KIND_CTRL: kind_mask = 3'b001;
			KIND_SIG:  kind_mask = 3'b010;
			KIND_BMP:  kind_mask = 3'b100;
			default:   kind_mask = 3'b000;
		endcase
	end

	// A link counts as down if any slot carrying its id holds a mark.
	always_comb begin
		any_mark   = 1'b0;
		has_kind   = 1'b0;
		other_mark = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			if (match[s]) begin
				any_mark   = any_mark | (|mark_q[s]);
				has_kind   = has_kind | (|(mark_q[s] & kind_mask));
				other_mark = other_mark | (|(mark_q[s] & ~kind_mask));
			end
		end
	end

	assign known      = |match;
	assign evt_active = (func_q != FN_QUERY) && (func_q != FN_RESERVED);
	assign set_ev     = evt_active && !func_q[0];
	assign clr_ev     = evt_active && func_q[0] && has_kind;
	assign need       = known && ((set_ev && !any_mark) || (clr_ev && !other_mark));

	// Up test for the slot under scan checks every in-use slot with the same id.
	always_comb begin
		scan_id = slot_id[scan_idx_q];
		scan_up = 1'b1;
		for (int t = 0; t < SLOTS; t++) begin
			if (in_use[t] && (slot_id[t] == scan_id) && (|mark_q[t])) begin
				scan_up = 1'b0;
			end
		end
	end

	assign sts.reselect  = need && !fixed_q;
	assign sts.scan_last = scan_idx_q == SW'(SLOTS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_count_q <= '0;
			link_ids_q   <= '0;
			fixed_q      <= 1'b0;
			prefer_q     <= 1'b1;
			high_def_q   <= '0;
			low_def_q    <= '0;
			for (int s = 0; s < SLOTS; s++) begin
				mark_q[s] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LINK_COUNT:   link_count_q <= cfg_data[COUNT_W-1:0];
					CFG_LINK_IDS:     link_ids_q   <= cfg_data[ID_W*ID_FIELDS-1:0];
					CFG_INIT_HIGH_ID: high_def_q   <= cfg_data[ID_W-1:0];
					CFG_INIT_LOW_ID:  low_def_q    <= cfg_data[ID_W-1:0];
					CFG_FIXED:        fixed_q      <= cfg_data[0];
					CFG_PREFER_LARGE: prefer_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.update) begin
				for (int s = 0; s < SLOTS; s++) begin
					if (match[s]) begin
						if (set_ev) begin
							mark_q[s] <= mark_q[s] | kind_mask;
						end else if (clr_ev) begin
							mark_q[s] <= mark_q[s] & ~kind_mask;
						end
					end
				end
			end
			// With no link up, the defaults stay as they are.
			if (cmd.commit && reselect_q && any_q) begin
				if (prefer_q) begin
					high_def_q <= hi_q;
					low_def_q  <= lo_q;
				end else begin
					high_def_q <= lo_q;
					low_def_q  <= hi_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= evt_func;
			id_q   <= evt_link_id;
		end
		if (cmd.update) begin
			reselect_q <= need && !fixed_q;
			// An up event reports a change even when the defaults are frozen.
			changed_q  <= known && ((set_ev && !any_mark && !fixed_q) ||
				(clr_ev && !other_mark));
			scan_idx_q <= '0;
			any_q      <= 1'b0;
		end
		if (cmd.scan) begin
			// The index stays on the last slot so it never points past the table.
			if (!sts.scan_last) begin
				scan_idx_q <= scan_idx_q + SW'(1);
			end
			if (in_use[scan_idx_q] && scan_up) begin
				if (!any_q || (scan_id < lo_q)) begin
					lo_q <= scan_id;
				end
				if (!any_q || (scan_id > hi_q)) begin
					hi_q <= scan_id;
				end
				any_q <= 1'b1;
			end
		end
		if (cmd.commit) begin
			up_q      <= known && !any_mark;
			unknown_q <= !known;
		end
	end

	assign res.default_changed = changed_q;
	assign res.link_is_up      = up_q;
	assign res.high_id         = high_def_q;
	assign res.low_id          = low_def_q;
	assign res.id_unknown      = unknown_q;

	a_hold_defaults: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !reselect_q && !cfg_we) |=> $stable(high_def_q) && $stable(low_def_q))
		else $error("defaults moved without a reselection");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> (scan_idx_q == '0) && !any_q)
		else $error("scan did not restart at the first slot");

	a_known_change: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !(changed_q && unknown_q))
		else $error("change reported for an unknown link id");

endmodule
